@@ sv/gpd_pkg.sv @@
// Shared constants and types for the grid path search block.
package gpd_pkg;

    // Default maze size.
    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;

    // Item kinds carried on the input tuser bit.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Input tdata layout, lowest bit first.
    localparam int IN_DATA_W   = 32;
    localparam int ROW_LSB     = 0;
    localparam int COL_LSB     = 4;
    localparam int OPEN_BIT    = 8;
    localparam int SROW_LSB    = 9;
    localparam int SCOL_LSB    = 13;
    localparam int EROW_LSB    = 17;
    localparam int ECOL_LSB    = 21;
    localparam int COORD_IN_W  = 4;

    // Output tdata layout.
    localparam int OUT_DATA_W  = 8;

    // Bits of one cell memory entry.
    localparam int CELL_OPEN_BIT    = 1;
    localparam int CELL_VISITED_BIT = 0;

    // Neighbor order tried around the current cell.
    typedef enum logic [1:0] {
        NB_SOUTH = 2'd0,
        NB_WEST  = 2'd1,
        NB_NORTH = 2'd2,
        NB_EAST  = 2'd3
    } nb_dir_t;

endpackage

@@ sv/grid_path_exists_dfs_top.sv @@
// Top level of the grid maze reachability block (depth-first search with a stack).
//
// A load item (tuser = 0) writes one cell's open bit into the cell memory and gives no
// result; loads outside the grid are dropped. A query item (tuser = 1) first sweeps the
// cell memory to clear every visited bit and mark the start cell visited, then walks
// the maze. For each cell it enters it issues four neighbor reads through the cell
// memory's single read port, checks the last neighbor, and then pops the next cell
// from the stack memory; when the last neighbor checked is open and unvisited it is
// taken straight on as the next cell and the pop is skipped. A query whose start lies
// outside the grid answers 0 without a search. One query is worked on at a time; while
// it runs the input is not ready. The result item holds path_found and waits in an
// output register, so the next item is taken while the result is still unread.
module grid_path_exists_dfs_top #(
    parameter int GRID_ROWS = gpd_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gpd_pkg::GRID_COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: row[3:0], col[7:4], cell_open[8], start_row[12:9],
    // start_col[16:13], end_row[20:17], end_col[24:21], zeros above.
    input  logic [gpd_pkg::IN_DATA_W-1:0]    s_tdata,
    // Fields from bit 0: func.
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: path_found[0], zeros above.
    output logic [gpd_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int RW         = $clog2(GRID_ROWS);
    localparam int CW         = $clog2(GRID_COLS);
    localparam int CAW        = RW + CW;
    localparam int CMEM_DEPTH = 1 << CAW;
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int SAW        = $clog2(CELL_COUNT);
    localparam int DW         = $clog2(CELL_COUNT + 1);
    localparam int IW         = gpd_pkg::COORD_IN_W;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_CLEAR    = 7'b0000010,
        ST_SCAN     = 7'b0000100,
        ST_DRAIN    = 7'b0001000,
        ST_POP      = 7'b0010000,
        ST_POP_WAIT = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    // Input fields.
    logic [IW-1:0] in_row, in_col, in_srow, in_scol, in_erow, in_ecol;
    logic          in_open;

    assign in_row  = s_tdata[gpd_pkg::ROW_LSB  +: IW];
    assign in_col  = s_tdata[gpd_pkg::COL_LSB  +: IW];
    assign in_open = s_tdata[gpd_pkg::OPEN_BIT];
    assign in_srow = s_tdata[gpd_pkg::SROW_LSB +: IW];
    assign in_scol = s_tdata[gpd_pkg::SCOL_LSB +: IW];
    assign in_erow = s_tdata[gpd_pkg::EROW_LSB +: IW];
    assign in_ecol = s_tdata[gpd_pkg::ECOL_LSB +: IW];

    // Registers.
    state_t           state_reg, state_next;
    logic [CAW:0]     clr_cnt_reg, clr_cnt_next;
    logic             wb_valid_reg, wb_valid_next;
    logic [CAW-1:0]   wb_addr_reg, wb_addr_next;
    logic [RW-1:0]    start_r_reg, start_r_next;
    logic [CW-1:0]    start_c_reg, start_c_next;
    logic [IW-1:0]    end_r_reg, end_r_next;
    logic [IW-1:0]    end_c_reg, end_c_next;
    logic [RW-1:0]    cur_r_reg, cur_r_next;
    logic [CW-1:0]    cur_c_reg, cur_c_next;
    gpd_pkg::nb_dir_t k_reg, k_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [RW-1:0]    chk_r_reg, chk_r_next;
    logic [CW-1:0]    chk_c_reg, chk_c_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic             found_reg, found_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;

    // Memory ports.
    logic             cmem_we;
    logic [CAW-1:0]   cmem_waddr, cmem_raddr;
    logic [1:0]       cmem_wdata, cmem_rdata;
    logic             smem_we;
    logic [SAW-1:0]   smem_waddr, smem_raddr;
    logic [CAW-1:0]   smem_wdata, smem_rdata;

    // Combinational helpers.
    logic             nb_in;
    logic [RW-1:0]    nb_r;
    logic [CW-1:0]    nb_c;
    logic             chk_push;
    logic [DW-1:0]    depth_dec;
    logic             enter_en;
    logic [RW-1:0]    enter_r;
    logic [CW-1:0]    enter_c;
    logic             enter_hit;

    gpd_ram #(
        .WIDTH (2),
        .DEPTH (CMEM_DEPTH)
    ) u_cell_mem (
        .clk   (clk),
        .we    (cmem_we),
        .waddr (cmem_waddr),
        .wdata (cmem_wdata),
        .raddr (cmem_raddr),
        .rdata (cmem_rdata)
    );

    gpd_ram #(
        .WIDTH (CAW),
        .DEPTH (CELL_COUNT)
    ) u_stack_mem (
        .clk   (clk),
        .we    (smem_we),
        .waddr (smem_waddr),
        .wdata (smem_wdata),
        .raddr (smem_raddr),
        .rdata (smem_rdata)
    );

    // Neighbor of the current cell in the direction being tried; cells off the grid
    // count as walls and their reads are never checked.
    always_comb
    begin
        nb_r  = cur_r_reg;
        nb_c  = cur_c_reg;
        nb_in = 1'b0;
        case (k_reg)
            gpd_pkg::NB_SOUTH:
            begin
                nb_in = (cur_r_reg != RW'(GRID_ROWS - 1));
                nb_r  = cur_r_reg + RW'(1);
            end
            gpd_pkg::NB_WEST:
            begin
                nb_in = (cur_c_reg != '0);
                nb_c  = cur_c_reg - CW'(1);
            end
            gpd_pkg::NB_NORTH:
            begin
                nb_in = (cur_r_reg != '0);
                nb_r  = cur_r_reg - RW'(1);
            end
            gpd_pkg::NB_EAST:
            begin
                nb_in = (cur_c_reg != CW'(GRID_COLS - 1));
                nb_c  = cur_c_reg + CW'(1);
            end
            default:
            begin
                nb_in = 1'b0;
            end
        endcase
    end

    assign chk_push  = chk_valid_reg && cmem_rdata[gpd_pkg::CELL_OPEN_BIT]
                       && !cmem_rdata[gpd_pkg::CELL_VISITED_BIT];
    assign depth_dec = depth_reg - DW'(1);

    assign smem_raddr = depth_dec[SAW-1:0];
    assign smem_waddr = depth_reg[SAW-1:0];
    assign smem_wdata = {chk_r_reg, chk_c_reg};

    assign enter_hit = (32'(enter_r) == 32'(end_r_reg)) && (32'(enter_c) == 32'(end_c_reg));

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        start_r_next   = start_r_reg;
        start_c_next   = start_c_reg;
        end_r_next     = end_r_reg;
        end_c_next     = end_c_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        k_next         = k_reg;
        chk_valid_next = 1'b0;
        chk_r_next     = nb_r;
        chk_c_next     = nb_c;
        depth_next     = depth_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;

        cmem_we    = 1'b0;
        cmem_waddr = {chk_r_reg, chk_c_reg};
        cmem_wdata = 2'b11;
        cmem_raddr = {nb_r, nb_c};
        smem_we    = 1'b0;

        enter_en = 1'b0;
        enter_r  = start_r_reg;
        enter_c  = start_c_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == gpd_pkg::FUNC_LOAD)
                    begin
                        cmem_we    = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
                        cmem_waddr = {RW'(in_row), CW'(in_col)};
                        cmem_wdata = {in_open, 1'b0};
                    end
                    else
                    begin
                        start_r_next = RW'(in_srow);
                        start_c_next = CW'(in_scol);
                        end_r_next   = in_erow;
                        end_c_next   = in_ecol;
                        depth_next   = '0;
                        clr_cnt_next = '0;
                        if ((32'(in_srow) < GRID_ROWS) && (32'(in_scol) < GRID_COLS))
                        begin
                            state_next = ST_CLEAR;
                        end
                        else
                        begin
                            found_next = 1'b0;
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            // Read each entry, then write it back in the following cycle with the visited
            // bit cleared; the start cell is marked visited on the way.
            ST_CLEAR:
            begin
                cmem_raddr = clr_cnt_reg[CAW-1:0];
                cmem_we    = wb_valid_reg;
                cmem_waddr = wb_addr_reg;
                cmem_wdata = {cmem_rdata[gpd_pkg::CELL_OPEN_BIT],
                              (wb_addr_reg == {start_r_reg, start_c_reg})};
                if (clr_cnt_reg != (CAW+1)'(CMEM_DEPTH))
                begin
                    wb_valid_next = 1'b1;
                    wb_addr_next  = clr_cnt_reg[CAW-1:0];
                    clr_cnt_next  = clr_cnt_reg + (CAW+1)'(1);
                end
                else if (!wb_valid_reg)
                begin
                    enter_en = 1'b1;
                    enter_r  = start_r_reg;
                    enter_c  = start_c_reg;
                end
            end

            // One neighbor read issued per cycle; the read from the cycle before is
            // checked and, if open and unvisited, marked and pushed.
            ST_SCAN:
            begin
                chk_valid_next = nb_in;
                if (chk_push)
                begin
                    cmem_we    = 1'b1;
                    smem_we    = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
                if (k_reg == gpd_pkg::NB_EAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = gpd_pkg::nb_dir_t'(k_reg + 2'd1);
                end
            end

            // A pushed last neighbor would be popped at once, so it goes straight on.
            ST_DRAIN:
            begin
                if (chk_push)
                begin
                    cmem_we  = 1'b1;
                    enter_en = 1'b1;
                    enter_r  = chk_r_reg;
                    enter_c  = chk_c_reg;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    found_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    depth_next = depth_dec;
                    state_next = ST_POP_WAIT;
                end
            end

            ST_POP_WAIT:
            begin
                enter_en = 1'b1;
                enter_r  = smem_rdata[CAW-1:CW];
                enter_c  = smem_rdata[CW-1:0];
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A cell entered: answer if it is the end cell, else scan it.
        if (enter_en)
        begin
            cur_r_next = enter_r;
            cur_c_next = enter_c;
            k_next     = gpd_pkg::NB_SOUTH;
            if (enter_hit)
            begin
                found_next = 1'b1;
                state_next = ST_FINISH;
            end
            else
            begin
                state_next = ST_SCAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_cnt_reg   <= '0;
            wb_valid_reg  <= 1'b0;
            k_reg         <= gpd_pkg::NB_SOUTH;
            chk_valid_reg <= 1'b0;
            depth_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wb_valid_reg  <= wb_valid_next;
            k_reg         <= k_next;
            chk_valid_reg <= chk_valid_next;
            depth_reg     <= depth_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg   <= wb_addr_next;
        start_r_reg   <= start_r_next;
        start_c_reg   <= start_c_next;
        end_r_reg     <= end_r_next;
        end_c_reg     <= end_c_next;
        cur_r_reg     <= cur_r_next;
        cur_c_reg     <= cur_c_next;
        chk_r_reg     <= chk_r_next;
        chk_c_reg     <= chk_c_next;
        out_found_reg <= out_found_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gpd_pkg::OUT_DATA_W-1){1'b0}}, out_found_reg};

`ifndef SYNTHESIS
    // The stack never holds more cells than the grid has.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(CELL_COUNT))
        else $error("stack depth beyond grid size");

    // A pop from a non-empty stack takes exactly one entry off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP && depth_reg != '0) |=> depth_reg == $past(depth_dec))
        else $error("pop did not take one entry");

    // The last neighbor check follows the east neighbor read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> ($past(state_reg) == ST_SCAN
                                     && $past(k_reg) == gpd_pkg::NB_EAST))
        else $error("drain entered out of order");

    // No pending neighbor check outside the scan and drain states.
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("stray neighbor check");
`endif

endmodule

@@ sv/gpd_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module gpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the grid maze reachability block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS    = gpd_pkg::GRID_ROWS_DEF;
    localparam int COLS    = gpd_pkg::GRID_COLS_DEF;
    localparam int N_SITES = ROWS * COLS;

    // A whole query can pass with nothing moving on either side, and the
    // backpressure test holds the result side for HOLD_CYCLES. The watchdog
    // limit, STALL_LIMIT, sits well above both.
    localparam int HOLD_CYCLES = 6000;
    localparam int STALL_LIMIT = 20000;

    // One input item, before packing onto the stream.
    typedef struct {
        logic       func;
        logic [3:0] row;
        logic [3:0] col;
        logic       cell_open;
        logic [3:0] start_row;
        logic [3:0] start_col;
        logic [3:0] end_row;
        logic [3:0] end_col;
    } maze_item_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // Fields from bit 0: row, col, cell_open, start_row, start_col, end_row,
    // end_col, zeros above.
    logic [gpd_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    // Fields from bit 0: func.
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // Fields from bit 0: path_found, zeros above.
    logic [gpd_pkg::OUT_DATA_W-1:0] m_tdata;

    // Our own copy of the maze, updated as load items are accepted.
    bit maze_open [N_SITES];

    // Expected path_found answers, oldest first.
    bit found_q [$];

    int n_errors      = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold_req = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    grid_path_exists_dfs_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Depth-first search over our maze copy. The start cell is taken even when
    // it is a wall; a neighbor is taken only when it lies inside the grid, is
    // open and has not been seen. The answer is whether the end cell comes off
    // the stack.
    function automatic bit path_exists(input logic [3:0] sr, input logic [3:0] sc,
                                       input logic [3:0] er, input logic [3:0] ec);
        bit seen [N_SITES];
        int stack [$];
        int idx;
        int r;
        int c;
        int nr;
        int nc;
        if (sr >= ROWS || sc >= COLS)
            return 1'b0;
        seen[sr * COLS + sc] = 1'b1;
        stack.push_back(sr * COLS + sc);
        while (stack.size() > 0)
        begin
            idx = stack.pop_back();
            r = idx / COLS;
            c = idx % COLS;
            if (r == er && c == ec)
                return 1'b1;
            for (int d = 0; d < 4; d++)
            begin
                nr = r;
                nc = c;
                case (gpd_pkg::nb_dir_t'(d))
                    gpd_pkg::NB_SOUTH: nr = r + 1;
                    gpd_pkg::NB_WEST:  nc = c - 1;
                    gpd_pkg::NB_NORTH: nr = r - 1;
                    gpd_pkg::NB_EAST:  nc = c + 1;
                    default:           nr = r;
                endcase
                if (nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS)
                begin
                    if (maze_open[nr * COLS + nc] && !seen[nr * COLS + nc])
                    begin
                        seen[nr * COLS + nc] = 1'b1;
                        stack.push_back(nr * COLS + nc);
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [gpd_pkg::IN_DATA_W-1:0] pack_item(input maze_item_t it);
        logic [gpd_pkg::IN_DATA_W-1:0] data;
        data = '0;
        data[gpd_pkg::ROW_LSB  +: gpd_pkg::COORD_IN_W] = it.row;
        data[gpd_pkg::COL_LSB  +: gpd_pkg::COORD_IN_W] = it.col;
        data[gpd_pkg::OPEN_BIT]                        = it.cell_open;
        data[gpd_pkg::SROW_LSB +: gpd_pkg::COORD_IN_W] = it.start_row;
        data[gpd_pkg::SCOL_LSB +: gpd_pkg::COORD_IN_W] = it.start_col;
        data[gpd_pkg::EROW_LSB +: gpd_pkg::COORD_IN_W] = it.end_row;
        data[gpd_pkg::ECOL_LSB +: gpd_pkg::COORD_IN_W] = it.end_col;
        return data;
    endfunction

    // Offers one item, idling at random before it, and waits for the handshake.
    // It is entered and left at a rising edge, so valid gets one assignment per
    // step and stays high across back-to-back items. On acceptance the maze copy
    // is updated for a load, or the expected answer is queued for a query.
    task automatic send_item(input maze_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= pack_item(it);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (it.func == gpd_pkg::FUNC_LOAD)
            maze_open[it.row * COLS + it.col] = it.cell_open;
        else
            found_q.push_back(path_exists(it.start_row, it.start_col,
                                          it.end_row, it.end_col));
    endtask

    // The fields a load does not use carry random noise, and so do the
    // load fields of a query.
    task automatic send_load(input int r, input int c, input bit is_open);
        maze_item_t it;
        it.func      = gpd_pkg::FUNC_LOAD;
        it.row       = 4'(r);
        it.col       = 4'(c);
        it.cell_open = is_open;
        it.start_row = 4'($urandom_range(15));
        it.start_col = 4'($urandom_range(15));
        it.end_row   = 4'($urandom_range(15));
        it.end_col   = 4'($urandom_range(15));
        send_item(it);
    endtask

    task automatic send_query(input int sr, input int sc, input int er, input int ec);
        maze_item_t it;
        it.func      = gpd_pkg::FUNC_QUERY;
        it.row       = 4'($urandom_range(15));
        it.col       = 4'($urandom_range(15));
        it.cell_open = 1'($urandom_range(1));
        it.start_row = 4'(sr);
        it.start_col = 4'(sc);
        it.end_row   = 4'(er);
        it.end_col   = 4'(ec);
        send_item(it);
    endtask

    // Every cell must be written before any query may look at it, so the whole
    // grid is loaded open first. This also walks row and col through all values.
    task automatic test_load_maze();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                send_load(r, c, 1'b1);
    endtask

    // Corner to corner on a fully open maze gives the longest walks.
    task automatic test_corner_paths();
        send_query(0, 0, ROWS - 1, COLS - 1);
        send_query(ROWS - 1, COLS - 1, 0, 0);
        send_query(0, COLS - 1, ROWS - 1, 0);
        send_query(7, 7, 7, 7);
    endtask

    // A walled start cell is still taken, so start equal to end answers 1 and
    // the walk leaves it; a walled end cell is never reached.
    task automatic test_wall_endpoints();
        send_load(5, 5, 1'b0);
        send_query(5, 5, 5, 5);
        send_query(5, 5, 9, 3);
        send_query(0, 0, 5, 5);
        send_load(5, 5, 1'b1);
    endtask

    // Seal corners in with walls; the grid edge must act as a wall as well.
    task automatic test_sealed_corners();
        send_load(0, 1, 1'b0);
        send_load(1, 0, 1'b0);
        send_query(0, 0, ROWS - 1, COLS - 1);
        send_query(ROWS - 1, COLS - 1, 0, 0);
        send_query(0, 0, 0, 0);
        send_load(ROWS - 1, COLS - 2, 1'b0);
        send_load(ROWS - 2, COLS - 1, 1'b0);
        send_query(0, COLS - 1, ROWS - 1, COLS - 1);
        send_query(ROWS - 1, COLS - 1, ROWS - 1, COLS - 1);
        send_load(0, 1, 1'b1);
        send_load(1, 0, 1'b1);
    endtask

    // Rounds of a few cell rewrites followed by one or two queries. The share
    // of open cells written drifts between rounds, so the maze moves between
    // well connected and broken up, around where reachability is hard to guess.
    task automatic test_random_walks(input int n_items);
        int sent;
        int density;
        sent    = 0;
        density = 75;
        while (sent < n_items)
        begin
            if ($urandom_range(7) == 0)
                density = 40 + $urandom_range(60);
            repeat ($urandom_range(8))
            begin
                send_load($urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                          $urandom_range(99) < density);
                sent++;
            end
            repeat (1 + $urandom_range(1))
            begin
                if ($urandom_range(5) == 0)
                    begin
                        int r;
                        int c;
                        r = $urandom_range(ROWS - 1);
                        c = $urandom_range(COLS - 1);
                        send_query(r, c, r, c);
                    end
                else
                    send_query($urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                               $urandom_range(ROWS - 1), $urandom_range(COLS - 1));
                sent++;
            end
        end
    endtask

    // The result side holds off long enough for one answer to sit in the output
    // register and a second query to finish behind it, so the block has to stop
    // taking items while the sender keeps offering more.
    task automatic test_output_backpressure();
        recv_hold_req = HOLD_CYCLES;
        repeat (4)
            send_query($urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                       $urandom_range(ROWS - 1), $urandom_range(COLS - 1));
    endtask

    // Result side ready, with random stalls and the long hold asked for above.
    always @(posedge clk)
    begin
        if (recv_hold_req > 0)
        begin
            hold_left     = recv_hold_req;
            recv_hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each accepted result is matched against the oldest expected answer.
    always @(posedge clk)
    begin
        logic [gpd_pkg::OUT_DATA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (found_q.size() == 0)
            begin
                $display("%0t ns: result 0x%0h arrived with no query outstanding",
                         $time, m_tdata);
                n_errors++;
            end
            else
            begin
                want = gpd_pkg::OUT_DATA_W'(found_q.pop_front());
                if (m_tdata !== want)
                begin
                    $display("%0t ns: path_found mismatch, expected 0x%0h, got 0x%0h",
                             $time, want, m_tdata);
                    n_errors++;
                end
            end
        end
    end

    // Ends the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First phase: sender idles a quarter of the time, receiver almost half.
        send_idle_pct = 25;
        recv_idle_pct = 46;
        test_load_maze();
        test_corner_paths();
        test_wall_endpoints();
        test_sealed_corners();
        test_random_walks(40);

        // Second phase: the idle shares swap sides.
        send_idle_pct = 46;
        recv_idle_pct = 25;
        test_random_walks(40);

        // Last phase: both sides at full rate.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_walks(40);
        test_output_backpressure();

        // Stop offering, let every answer come back, then watch a little longer
        // for anything unexpected.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (found_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/gpd_pkg.sv
sv/gpd_ram.sv
sv/grid_path_exists_dfs_top.sv
bench/tb.sv
